[hw/rtl/i2cmra_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types and constants of the I2C master register access block.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

    // Request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Transfer status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ADDR_NAK = 2'd1;
    localparam logic [1:0] STATUS_DATA_NAK = 2'd2;

    // Configuration register indexes
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd20;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_LO   = 4'd1,
        PH_ST_HI   = 4'd2,
        PH_ST_HOLD = 4'd3,
        PH_BIT_LO  = 4'd4,
        PH_BIT_HI  = 4'd5,
        PH_ACK_LO  = 4'd6,
        PH_ACK_HI  = 4'd7,
        PH_RB_LO   = 4'd8,
        PH_RB_HI   = 4'd9,
        PH_NK_LO   = 4'd10,
        PH_NK_HI   = 4'd11,
        PH_SP_LO   = 4'd12,
        PH_SP_HI   = 4'd13,
        PH_SP_REL  = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        SG_ADDR  = 2'd0,
        SG_REG   = 2'd1,
        SG_DATA  = 2'd2,
        SG_RADDR = 2'd3
    } stage_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } result_t;

    // Sequencer state, less the phase tick counter (its width is a parameter)
    typedef struct packed {
        phase_t     phase;
        stage_t     stage;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] ack_wait;
        logic [7:0] held_device;
        logic [7:0] held_register;
        logic [7:0] held_data;
        logic       is_read;
        logic [1:0] last_status;
        logic [7:0] rx_byte;
    } seq_state_t;

endpackage

[hw/rtl/i2cmra_stream_if.sv]
// ----------------------------------------------------------------------------
// i2cmra_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface i2cmra_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/i2cmra_step.sv]
// ----------------------------------------------------------------------------
// i2cmra_step
// One tick of the I2C sequencer: request load, pin drive and next state.
// ----------------------------------------------------------------------------
module i2cmra_step
    import i2cmra_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  seq_state_t              cur,
    input  logic [TICK_WIDTH-1:0]   tick_cur,
    input  logic [15:0]             half_period,
    input  logic [7:0]              ack_timeout,
    input  item_t                   item,
    output seq_state_t              nxt,
    output logic [TICK_WIDTH-1:0]   tick_nxt,
    output result_t                 res
);

    localparam logic [32:0] TICK_MAX = (33'd1 << TICK_WIDTH) - 33'd1;

    seq_state_t            s;
    logic [TICK_WIDTH-1:0] tk;
    logic [32:0]           len;
    logic [32:0]           tick_inc;
    logic                  over;
    logic [7:0]            ack_lim;
    logic [7:0]            ack_inc;
    logic                  ack_missing;
    logic                  ack_end;
    logic [2:0]            bit_inc;
    logic [7:0]            rb_shift;
    logic                  done;
    logic                  scl_d;
    logic                  sda_d;

    // Phase length: zero reads as one, saturate to the counter range
    always_comb
    begin
        len = {17'd0, half_period};
        if (len == 33'd0)
            len = 33'd1;
        if (len > TICK_MAX)
            len = TICK_MAX;
    end

    always_comb
    begin
        s  = cur;
        tk = tick_cur;
        if (cur.phase == PH_IDLE && (item.kind == KIND_WRITE || item.kind == KIND_READ))
        begin
            s.held_device   = item.device_addr;
            s.held_register = item.reg_addr;
            s.held_data     = item.write_data;
            s.is_read       = (item.kind == KIND_READ);
            s.last_status   = STATUS_OK;
            s.stage         = SG_ADDR;
            s.bit_count     = 3'd0;
            s.ack_wait      = 8'd0;
            s.phase         = PH_ST_LO;
            tk              = '0;
        end
    end

    // Pin drive for this tick
    always_comb
    begin
        case (s.phase)
            PH_ST_LO:                       begin scl_d = 1'b0; sda_d = 1'b1; end
            PH_ST_HOLD:                     begin scl_d = 1'b1; sda_d = 1'b0; end
            PH_BIT_LO:                      begin scl_d = 1'b0; sda_d = s.shift_byte[7]; end
            PH_BIT_HI:                      begin scl_d = 1'b1; sda_d = s.shift_byte[7]; end
            PH_ACK_LO, PH_RB_LO, PH_NK_LO:  begin scl_d = 1'b0; sda_d = 1'b1; end
            PH_SP_LO:                       begin scl_d = 1'b0; sda_d = 1'b0; end
            PH_SP_HI:                       begin scl_d = 1'b1; sda_d = 1'b0; end
            default:                        begin scl_d = 1'b1; sda_d = 1'b1; end
        endcase
    end

    assign tick_inc    = {{(33-TICK_WIDTH){1'b0}}, tk} + 33'd1;
    assign over        = (tick_inc >= len);
    assign ack_lim     = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
    assign ack_inc     = s.ack_wait + 8'd1;
    assign ack_missing = (ack_inc >= ack_lim);
    assign ack_end     = !item.sda_sample || ack_missing;
    assign bit_inc     = s.bit_count + 3'd1;
    assign rb_shift    = {s.shift_byte[6:0], item.sda_sample};

    always_comb
    begin
        nxt      = s;
        tick_nxt = tk;
        done     = 1'b0;
        // timed phases step the tick counter
        if (s.phase != PH_IDLE && s.phase != PH_ACK_HI)
            tick_nxt = over ? '0 : tick_inc[TICK_WIDTH-1:0];
        case (s.phase)
            PH_ST_LO:   if (over) nxt.phase = PH_ST_HI;
            PH_ST_HI:   if (over) nxt.phase = PH_ST_HOLD;
            PH_ST_HOLD:
                if (over)
                begin
                    nxt.shift_byte = (s.stage == SG_RADDR) ? s.held_device + 8'd1
                                                           : s.held_device;
                    nxt.bit_count  = 3'd0;
                    nxt.phase      = PH_BIT_LO;
                end
            PH_BIT_LO:  if (over) nxt.phase = PH_BIT_HI;
            PH_BIT_HI:
                if (over)
                begin
                    nxt.shift_byte = {s.shift_byte[6:0], 1'b0};
                    nxt.bit_count  = bit_inc;
                    nxt.phase      = (bit_inc == 3'd0) ? PH_ACK_LO : PH_BIT_LO;
                end
            PH_ACK_LO:
                if (over)
                begin
                    nxt.ack_wait = 8'd0;
                    nxt.phase    = PH_ACK_HI;
                end
            PH_ACK_HI:
            begin
                if (item.sda_sample)
                    nxt.ack_wait = ack_inc;
                if (ack_end)
                begin
                    tick_nxt = '0;
                    case (s.stage)
                        SG_ADDR:
                            if (item.sda_sample)
                            begin
                                nxt.last_status = STATUS_ADDR_NAK;
                                nxt.phase       = PH_SP_LO;
                            end
                            else
                            begin
                                nxt.stage      = SG_REG;
                                nxt.shift_byte = s.held_register;
                                nxt.bit_count  = 3'd0;
                                nxt.phase      = PH_BIT_LO;
                            end
                        SG_REG:
                            if (s.is_read)
                            begin
                                nxt.stage = SG_RADDR;
                                nxt.phase = PH_ST_LO;
                            end
                            else
                            begin
                                nxt.stage      = SG_DATA;
                                nxt.shift_byte = s.held_data;
                                nxt.bit_count  = 3'd0;
                                nxt.phase      = PH_BIT_LO;
                            end
                        SG_DATA:
                        begin
                            if (item.sda_sample)
                                nxt.last_status = STATUS_DATA_NAK;
                            nxt.phase = PH_SP_LO;
                        end
                        default:
                        begin
                            nxt.shift_byte = 8'd0;
                            nxt.bit_count  = 3'd0;
                            nxt.phase      = PH_RB_LO;
                        end
                    endcase
                end
            end
            PH_RB_LO:   if (over) nxt.phase = PH_RB_HI;
            PH_RB_HI:
                if (over)
                begin
                    nxt.shift_byte = rb_shift;
                    nxt.bit_count  = bit_inc;
                    if (bit_inc == 3'd0)
                    begin
                        nxt.rx_byte = rb_shift;
                        nxt.phase   = PH_NK_LO;
                    end
                    else
                        nxt.phase = PH_RB_LO;
                end
            PH_NK_LO:   if (over) nxt.phase = PH_NK_HI;
            PH_NK_HI:   if (over) nxt.phase = PH_SP_LO;
            PH_SP_LO:   if (over) nxt.phase = PH_SP_HI;
            PH_SP_HI:   if (over) nxt.phase = PH_SP_REL;
            PH_SP_REL:
                if (over)
                begin
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
            default:    nxt.phase = PH_IDLE;
        endcase
    end

    always_comb
    begin
        res.scl_out   = scl_d;
        res.sda_out   = sda_d;
        res.busy_res  = (nxt.phase != PH_IDLE);
        res.done_res  = done;
        res.status    = nxt.last_status;
        res.read_data = nxt.rx_byte;
    end

endmodule

[hw/rtl/i2c_master_register_access.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Open-drain I2C master for single-byte register writes and reads.
// ----------------------------------------------------------------------------
// Each transaction on item is one tick of the I2C bit timing and gives exactly
// one transaction on result, carrying the SCL/SDA drive for that tick and the
// transfer status. Throughput is one transaction per clock cycle while result
// is not stalled; the result register behind the single-tick sequencer step
// gives the result in the cycle after the item is taken. item.ready stays high
// while result is empty or being taken, so results stall only at the consumer.
// Configuration (half_period, ack_timeout) must be written while idle.
// ----------------------------------------------------------------------------
module i2c_master_register_access
    import i2cmra_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    i2cmra_stream_if.sink   item,
    i2cmra_stream_if.source result
);

    // Configuration registers
    logic [15:0] half_period_reg;
    logic [7:0]  ack_timeout_reg;

    // Sequencer state
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TICK_WIDTH-1:0] tick_count_reg;
    logic [TICK_WIDTH-1:0] tick_count_next;

    // Result register
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_data_next;

    item_t item_data;
    logic  accept;

    assign item_data  = item.payload;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data;
                REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Single-tick step: request load, pin drive, phase advance
    i2cmra_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .cur         (state_reg),
        .tick_cur    (tick_count_reg),
        .half_period (half_period_reg),
        .ack_timeout (ack_timeout_reg),
        .item        (item_data),
        .nxt         (state_next),
        .tick_nxt    (tick_count_next),
        .res         (out_data_next)
    );

    // State moves only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{phase: PH_IDLE, stage: SG_ADDR, default: '0};
            tick_count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // Every accepted tick leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted transaction produced no result");

    // ACK wait never sits at or above its limit
    a_ack_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_ACK_HI |->
            state_reg.ack_wait < ((ack_timeout_reg == 8'd0) ? 8'd1 : ack_timeout_reg))
        else $error("ack wait counter passed its limit");

    // Pending result agrees with the sequencer state it was built with
    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.payload.busy_res == (state_reg.phase != PH_IDLE))
        else $error("busy flag out of step with sequencer");
`endif

endmodule
